// ----- sv/mtwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtwg_pkg
// Shared types, constants and the output tempering function of the
// 32-bit twister word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtwg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS + 1);
    localparam int WORD_W       = 32;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    // command codes of the op field
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_SEED     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_TW_LOAD0,
        ST_TW_CUR0,
        ST_TW_NXT,
        ST_TW_FAR,
        ST_TW_WR,
        ST_GEN_RD,
        ST_GEN_DATA
    } state_t;

    // store access requested by the sequencer
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    // raw word handed to the output stage
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } word_xfer_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mtwg_in_if.sv -----
// ----------------------------------------------------------------------------
// mtwg_in_if
// Command channel: op and seed word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtwg_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [mtwg_pkg::WORD_W-1:0]    seed_value;

    modport source (output valid, output op, output seed_value, input ready);
    modport sink   (input valid, input op, input seed_value, output ready);
endinterface

`default_nettype wire

// ----- sv/mtwg_out_if.sv -----
// ----------------------------------------------------------------------------
// mtwg_out_if
// Result channel: one tempered random word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtwg_out_if;
    logic                           valid;
    logic                           ready;
    logic [mtwg_pkg::WORD_W-1:0]    random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ----- sv/mtwg_ram.sv -----
// ----------------------------------------------------------------------------
// mtwg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/mtwg_engine.sv -----
// ----------------------------------------------------------------------------
// mtwg_engine
// Sequencer for seeding, whole-store twist and word fetch, with the seed
// multiplier and the twist datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mtwg_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              legacy_mode,
    input  wire logic                              cmd_valid,
    input  wire logic                              cmd_op,
    input  wire logic [mtwg_pkg::WORD_W-1:0]       cmd_seed,
    output logic                                   cmd_ready,
    input  wire logic                              out_hold,
    output mtwg_pkg::word_xfer_t                   xfer,
    output mtwg_pkg::ram_req_t                     ram_req,
    input  wire logic [mtwg_pkg::WORD_W-1:0]       ram_rdata
);

    localparam logic [mtwg_pkg::IDX_W-1:0] LAST_IDX =
        mtwg_pkg::IDX_W'(mtwg_pkg::STATE_WORDS - 1);
    localparam logic [mtwg_pkg::IDX_W-1:0] FULL_IDX =
        mtwg_pkg::IDX_W'(mtwg_pkg::STATE_WORDS);
    localparam logic [mtwg_pkg::IDX_W:0] OFFSET_EXT =
        (mtwg_pkg::IDX_W + 1)'(mtwg_pkg::TWIST_OFFSET);
    localparam logic [mtwg_pkg::IDX_W:0] DEPTH_EXT =
        (mtwg_pkg::IDX_W + 1)'(mtwg_pkg::STATE_WORDS);

    mtwg_pkg::state_t state_reg, state_next;

    logic [mtwg_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [mtwg_pkg::IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic                        gen_pend_reg, gen_pend_next;
    logic [mtwg_pkg::WORD_W-1:0] p_reg, p_next;
    logic [mtwg_pkg::WORD_W-1:0] prod_reg, prod_next;
    logic [mtwg_pkg::WORD_W-1:0] cur_reg, cur_next;
    logic [mtwg_pkg::WORD_W-1:0] nxt_reg, nxt_next;

    logic [mtwg_pkg::WORD_W-1:0]   mul_in;
    logic [mtwg_pkg::WORD_W-1:0]   mul_low;
    logic [mtwg_pkg::WORD_W-1:0]   seed_word;
    logic [mtwg_pkg::IDX_W:0]      far_sum;
    logic [mtwg_pkg::IDX_W-1:0]    far_idx;
    logic [mtwg_pkg::IDX_W-1:0]    nxt_idx;
    logic [mtwg_pkg::WORD_W-1:0]   mixed;
    logic                          odd_sel;
    logic [mtwg_pkg::WORD_W-1:0]   twist_word;

    // seed recurrence: one multiply, then add of the index
    assign mul_in    = p_reg ^ (p_reg >> 30);
    assign mul_low   = mtwg_pkg::SEED_MULT * mul_in;
    assign seed_word = prod_reg + mtwg_pkg::WORD_W'(idx_reg);

    // neighbor indexes with wrap around the store
    assign far_sum = {1'b0, idx_reg} + OFFSET_EXT;
    assign far_idx = (far_sum >= DEPTH_EXT) ? mtwg_pkg::IDX_W'(far_sum - DEPTH_EXT)
                                            : mtwg_pkg::IDX_W'(far_sum);
    assign nxt_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // far word arrives on ram_rdata in the write step
    assign mixed      = {cur_reg[31], nxt_reg[30:0]};
    assign odd_sel    = legacy_mode ? cur_reg[0] : nxt_reg[0];
    assign twist_word = ram_rdata ^ (mixed >> 1)
                      ^ (odd_sel ? mtwg_pkg::TWIST_MATRIX : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mtwg_pkg::ST_IDLE;
            rd_ptr_reg   <= '0;
            gen_pend_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            gen_pend_reg <= gen_pend_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rd_ptr_next   = rd_ptr_reg;
        gen_pend_next = gen_pend_reg;
        p_next        = p_reg;
        prod_next     = prod_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        cmd_ready     = 1'b0;
        xfer.valid    = 1'b0;
        xfer.word     = ram_rdata;
        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = twist_word;
        ram_req.raddr = rd_ptr_reg;

        unique case (state_reg)
            mtwg_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd_op == mtwg_pkg::OP_SEED)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = '0;
                        ram_req.wdata = cmd_seed;
                        p_next        = cmd_seed;
                        idx_next      = mtwg_pkg::IDX_W'(1);
                        gen_pend_next = 1'b0;
                        state_next    = mtwg_pkg::ST_SEED_MUL;
                    end
                    else if (rd_ptr_reg == FULL_IDX)
                    begin
                        gen_pend_next = 1'b1;
                        state_next    = mtwg_pkg::ST_TW_LOAD0;
                    end
                    else
                    begin
                        state_next = mtwg_pkg::ST_GEN_RD;
                    end
                end
            end
            mtwg_pkg::ST_SEED_MUL:
            begin
                prod_next  = mul_low;
                state_next = mtwg_pkg::ST_SEED_ADD;
            end
            mtwg_pkg::ST_SEED_ADD:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = seed_word;
                p_next        = seed_word;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = mtwg_pkg::ST_TW_LOAD0;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = mtwg_pkg::ST_SEED_MUL;
                end
            end
            mtwg_pkg::ST_TW_LOAD0:
            begin
                ram_req.raddr = '0;
                idx_next      = '0;
                state_next    = mtwg_pkg::ST_TW_CUR0;
            end
            mtwg_pkg::ST_TW_CUR0:
            begin
                cur_next      = ram_rdata;
                ram_req.raddr = nxt_idx;
                state_next    = mtwg_pkg::ST_TW_FAR;
            end
            mtwg_pkg::ST_TW_NXT:
            begin
                ram_req.raddr = nxt_idx;
                state_next    = mtwg_pkg::ST_TW_FAR;
            end
            mtwg_pkg::ST_TW_FAR:
            begin
                nxt_next      = ram_rdata;
                ram_req.raddr = far_idx;
                state_next    = mtwg_pkg::ST_TW_WR;
            end
            mtwg_pkg::ST_TW_WR:
            begin
                ram_req.we = 1'b1;
                // the old next word is the current word of the following step
                cur_next   = nxt_reg;
                if (idx_reg == LAST_IDX)
                begin
                    rd_ptr_next   = '0;
                    gen_pend_next = 1'b0;
                    state_next    = gen_pend_reg ? mtwg_pkg::ST_GEN_RD : mtwg_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = mtwg_pkg::ST_TW_NXT;
                end
            end
            mtwg_pkg::ST_GEN_RD:
            begin
                state_next = mtwg_pkg::ST_GEN_DATA;
            end
            mtwg_pkg::ST_GEN_DATA:
            begin
                // address held so read data stays put while the output is full
                if (!out_hold)
                begin
                    xfer.valid  = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    state_next  = mtwg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtwg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/mt19937_word_generator_core.sv -----
// ----------------------------------------------------------------------------
// mt19937_word_generator_core
// 32-bit twister word generator with a 624-word store and a legacy twist.
// ----------------------------------------------------------------------------
// Usage:
//   req carries op (generate or seed) and seed_value; rsp returns one
//   tempered random_word per generate command, none for a seed.
//   cfg_we/cfg_wdata write legacy_mode; write it only while idle.
// Timing:
//   a generate command reads its word through the registered read of the
//   single-read-port store, and no new command is taken until that word has
//   gone to the output register.
//   when all 624 words are used, the generate first twists the whole store
//   in place, reading the next word and the far word on the one read port
//   and then writing the new word, for each word of the store.
//   a seed writes word 0 from seed_value and runs each further word through
//   the seed multiplier (multiply, then add and write), then the full twist.
//   req.ready is low while a command is in progress.
// Reset:
//   rst_n clears the sequencer, the read pointer and legacy_mode; the store
//   holds no defined words until the first seed.
// Stall:
//   rsp has an output register; a new command is accepted while a word
//   waits, and the next word is held back until rsp.ready frees the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_word_generator_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata,
    mtwg_in_if.sink     req,
    mtwg_out_if.source  rsp
);

    logic                         legacy_mode_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [mtwg_pkg::WORD_W-1:0]  out_word_reg, out_word_next;
    logic                         out_hold;
    mtwg_pkg::word_xfer_t         xfer;
    mtwg_pkg::ram_req_t           ram_req;
    logic [mtwg_pkg::WORD_W-1:0]  ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legacy_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            legacy_mode_reg <= cfg_wdata;
        end
    end

    mtwg_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .legacy_mode (legacy_mode_reg),
        .cmd_valid   (req.valid),
        .cmd_op      (req.op),
        .cmd_seed    (req.seed_value),
        .cmd_ready   (req.ready),
        .out_hold    (out_hold),
        .xfer        (xfer),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    mtwg_ram #(
        .WIDTH (mtwg_pkg::WORD_W),
        .DEPTH (mtwg_pkg::STATE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register slot is busy until the item is taken
    assign out_hold = out_valid_reg && !rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (xfer.valid)
        begin
            out_valid_next = 1'b1;
            out_word_next  = mtwg_pkg::temper(xfer.word);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = out_word_reg;

endmodule

`default_nettype wire
